### rtl/sbpf_pkg.sv
// Shared constants and types for the sprite blitter with a paged framebuffer.
// Used by the top-level unit and by the testbench; has no dependencies.
`timescale 1ns / 1ps

package sbpf_pkg;

	localparam int FB_WIDTH_DEF  = 64;
	localparam int FB_HEIGHT_DEF = 128;

	localparam logic [3:0] SPRITE_MAX = 4'd8;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_DRAW  = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_CLR  = 6'b000010,
		S_DRD  = 6'b000100,
		S_DWR  = 6'b001000,
		S_RDB  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

endpackage

### rtl/sbpf_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing; instanced by the framebuffer unit.
`timescale 1ns / 1ps

module sbpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/sprite_blit_page_framebuffer_unit.sv
// A read fetches its byte into the result register; a draw visits 16 framebuffer bytes,
// with a read state and a write state for each; a clear writes all COLS*FB_HEIGHT bytes (1024 by default).
// Transactions are handled one at a time; the single RAM port pair sets the pace.
// Reset clears control state at once, then a clearing pass writes zero to every framebuffer
// byte, one per cycle, while in_ready stays low.
`timescale 1ns / 1ps

module sprite_blit_page_framebuffer_unit
	import sbpf_pkg::*;
#(
	parameter int FB_WIDTH  = FB_WIDTH_DEF,
	parameter int FB_HEIGHT = FB_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [7:0]  pos_x,
	input  logic [7:0]  pos_y,
	input  logic [3:0]  sprite_width,
	input  logic [3:0]  sprite_height,
	input  logic [63:0] sprite_pixels,
	input  logic [9:0]  read_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_byte,
	output logic        done_res
);

	localparam int COLS  = (FB_WIDTH + 7) / 8;
	localparam int DEPTH = COLS * FB_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int WAW   = AW + 2;

	state_t         state_q;
	logic [AW-1:0]  cnt_q;
	logic           clr_report_q;
	logic [7:0]     x_q;
	logic [7:0]     y_q;
	logic [3:0]     w_q;
	logic [3:0]     h_q;
	logic [63:0]    pix_q;
	logic [3:0]     idx_q;
	logic           rd_oob_q;
	logic [7:0]     res_byte_q;
	logic           res_done_q;
	logic           out_valid_q;
	logic [7:0]     read_byte_q;
	logic           done_res_q;

	logic [7:0]     mask_s1;
	logic [7:0]     val_s1;
	logic [AW-1:0]  addr_s1;
	logic           ok_s1;

	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [7:0]     ram_wdata;
	logic [AW-1:0]  ram_raddr;
	logic [7:0]     ram_rdata;

	logic [2:0]     row;
	logic [5:0]     bc;
	logic [8:0]     ypix;
	logic [WAW-1:0] ent_addr;
	logic           ent_ok;
	logic [6:0]     row_base;
	logic [7:0]     mask_c;
	logic [7:0]     val_c;
	logic           accept;
	logic           out_load;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		logic [8:0] pxl;
		logic [8:0] dif;
		logic [5:0] pidx;
		row      = idx_q[3:1];
		bc       = 6'(x_q[7:3]) + 6'(idx_q[0]);
		ypix     = 9'(y_q) + 9'(row);
		ent_addr = WAW'(bc) * WAW'(FB_HEIGHT) + WAW'(ypix);
		ent_ok   = (4'(row) < h_q) && (ypix < 9'(FB_HEIGHT)) && (bc < 6'(COLS));
		row_base = 7'(row) * 7'(w_q);
		mask_c   = '0;
		val_c    = '0;
		for (int b = 0; b < 8; b++) begin
			pxl       = {bc, 3'(b)};
			dif       = pxl - 9'(x_q);
			pidx      = 6'(row_base + 7'(dif[2:0]));
			mask_c[b] = (pxl >= 9'(x_q)) && (dif < 9'(w_q)) && (pxl < 9'(FB_WIDTH));
			val_c[b]  = pix_q[6'd63 - pidx];
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = (ram_rdata & ~mask_s1) | (val_s1 & mask_s1);
		ram_raddr = ent_addr[AW-1:0];
		case (state_q)
			S_IDLE: begin
				ram_raddr = AW'(read_address);
			end
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
				ram_wdata = '0;
			end
			S_DWR: begin
				ram_we = ok_s1;
			end
			default: begin
			end
		endcase
	end

	sbpf_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_frame_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			cnt_q        <= '0;
			clr_report_q <= 1'b0;
			idx_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (operation)
							OP_CLEAR: begin
								cnt_q        <= '0;
								clr_report_q <= 1'b1;
								state_q      <= S_CLR;
							end
							OP_DRAW: begin
								idx_q   <= '0;
								state_q <= S_DRD;
							end
							OP_READ: begin
								state_q <= S_RDB;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == AW'(DEPTH - 1)) begin
						state_q <= clr_report_q ? S_DONE : S_IDLE;
					end
				end
				S_DRD: begin
					state_q <= S_DWR;
				end
				S_DWR: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= (idx_q == 4'hF) ? S_DONE : S_DRD;
				end
				S_RDB: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q      <= pos_x;
			y_q      <= pos_y;
			w_q      <= (sprite_width > SPRITE_MAX) ? SPRITE_MAX : sprite_width;
			h_q      <= (sprite_height > SPRITE_MAX) ? SPRITE_MAX : sprite_height;
			pix_q    <= sprite_pixels;
			rd_oob_q <= !(32'(read_address) < 32'(DEPTH));
			res_byte_q <= '0;
			res_done_q <= (operation == OP_CLEAR) || (operation == OP_DRAW) ||
				(operation == OP_READ);
		end
		if (state_q == S_RDB) begin
			res_byte_q <= rd_oob_q ? 8'h00 : ram_rdata;
		end
		if (state_q == S_DRD) begin
			mask_s1 <= mask_c;
			val_s1  <= val_c;
			addr_s1 <= ent_addr[AW-1:0];
			ok_s1   <= ent_ok;
		end
		if (out_load) begin
			read_byte_q <= res_byte_q;
			done_res_q  <= res_done_q;
		end
	end

	assign out_valid = out_valid_q;
	assign read_byte = read_byte_q;
	assign done_res  = done_res_q;

	a_we_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLR || state_q == S_DWR))
		else $error("framebuffer written outside a clear or draw write cycle");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> ram_we && ram_wdata == 8'h00)
		else $error("clearing pass did not write zero");

	a_draw_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && operation == OP_DRAW |=> state_q == S_DRD && idx_q == 4'h0)
		else $error("draw did not start at the first byte");

	a_byte_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && read_byte_q != 8'h00 |-> done_res_q)
		else $error("nonzero read byte without completion");

endmodule

### test/tb_sprite_blit_page_framebuffer_unit.sv
// Testbench for the sprite blitter: directed and random clear, draw, read and unused-code
// transactions, each result checked against an in-bench model of the framebuffer.
// Depends on sbpf_pkg and sprite_blit_page_framebuffer_unit.
`timescale 1ns / 1ps

module tb_sprite_blit_page_framebuffer_unit;
	import sbpf_pkg::*;

	localparam int FB_W = FB_WIDTH_DEF;
	localparam int FB_H = FB_HEIGHT_DEF;
	localparam int STORE_BYTES = ((FB_W + 7) / 8) * FB_H;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [63:0] PIX_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] PIX_CHECKER = 64'hAA55_AA55_AA55_AA55;
	localparam int RANDOM_PER_PHASE = 388;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [7:0] read_val;
		logic       done_flag;
	} blit_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  operation = OP_CLEAR;
	logic [7:0]  pos_x = 8'd0;
	logic [7:0]  pos_y = 8'd0;
	logic [3:0]  sprite_width = 4'd0;
	logic [3:0]  sprite_height = 4'd0;
	logic [63:0] sprite_pixels = 64'd0;
	logic [9:0]  read_address = 10'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  read_byte;
	logic        done_res;

	logic [7:0] frame_copy [STORE_BYTES];
	blit_result_t expected_results [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int n_errors = 0;
	int n_checked = 0;
	int n_draws = 0;
	int n_reads = 0;
	int n_clears = 0;
	int n_unused = 0;
	int last_x = 0;
	int last_y = 0;

	sprite_blit_page_framebuffer_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.sprite_width(sprite_width),
		.sprite_height(sprite_height),
		.sprite_pixels(sprite_pixels),
		.read_address(read_address),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_byte(read_byte),
		.done_res(done_res)
	);

	always #6 clk = ~clk;

	function automatic void paint_sprite(int x0, int y0, int w, int h, logic [63:0] pix);
		int cw, ch, p, px, py, a;
		cw = (w > SPRITE_MAX) ? SPRITE_MAX : w;
		ch = (h > SPRITE_MAX) ? SPRITE_MAX : h;
		for (int row = 0; row < ch; row++) begin
			for (int col = 0; col < cw; col++) begin
				p = row * cw + col;
				px = x0 + col;
				py = y0 + row;
				if (px < FB_W && py < FB_H) begin
					a = (px / 8) * FB_H + py;
					if (a < STORE_BYTES)
						frame_copy[a][px % 8] = pix[63 - p];
				end
			end
		end
	endfunction

	function automatic blit_result_t predict_blit(logic [1:0] op, logic [7:0] x, logic [7:0] y,
			logic [3:0] w, logic [3:0] h, logic [63:0] pix, logic [9:0] addr);
		blit_result_t r;
		r = '0;
		case (op)
			OP_CLEAR: begin
				foreach (frame_copy[i])
					frame_copy[i] = 8'h00;
				r.done_flag = 1'b1;
			end
			OP_DRAW: begin
				paint_sprite(x, y, w, h, pix);
				r.done_flag = 1'b1;
			end
			OP_READ: begin
				if (addr < STORE_BYTES)
					r.read_val = frame_copy[addr];
				r.done_flag = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_item(logic [1:0] op, logic [7:0] x, logic [7:0] y, logic [3:0] w,
			logic [3:0] h, logic [63:0] pix, logic [9:0] addr);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		pos_x <= x;
		pos_y <= y;
		sprite_width <= w;
		sprite_height <= h;
		sprite_pixels <= pix;
		read_address <= addr;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_results.push_back(predict_blit(op, x, y, w, h, pix, addr));
		case (op)
			OP_CLEAR: n_clears++;
			OP_DRAW: n_draws++;
			OP_READ: n_reads++;
			default: n_unused++;
		endcase
	endtask

	task automatic set_idling(int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	always @(posedge clk) begin
		blit_result_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: read_byte %02h, done_res %0b", read_byte, done_res);
				n_errors++;
			end else begin
				exp_res = expected_results.pop_front();
				n_checked++;
				if (read_byte !== exp_res.read_val) begin
					$error("read_byte mismatch: expected %02h, actual %02h",
						exp_res.read_val, read_byte);
					n_errors++;
				end
				if (done_res !== exp_res.done_flag) begin
					$error("done_res mismatch: expected %0b, actual %0b",
						exp_res.done_flag, done_res);
					n_errors++;
				end
			end
		end
	end

	// The reset clearing pass must leave both ends of the store at zero.
	task automatic test_reset_state();
		send_item(OP_READ, 8'd0, 8'd0, 4'd1, 4'd1, 64'd0, 10'd0);
		send_item(OP_READ, 8'hFF, 8'hFF, 4'hF, 4'hF, PIX_ONES, 10'd1023);
	endtask

	task automatic test_draw_extremes();
		send_item(OP_DRAW, 8'd0, 8'd0, 4'd8, 4'd8, PIX_ONES, 10'd0);
		send_item(OP_READ, 8'd0, 8'd0, 4'd0, 4'd0, 64'd0, 10'd0);
		send_item(OP_DRAW, 8'd56, 8'd120, 4'd8, 4'd8, PIX_CHECKER, 10'd0);
		send_item(OP_READ, 8'd0, 8'd0, 4'd0, 4'd0, 64'd0, 10'd1023);
		send_item(OP_DRAW, 8'd0, 8'd0, 4'd8, 4'd8, 64'd0, 10'h3FF);
		send_item(OP_READ, 8'd0, 8'd0, 4'd0, 4'd0, 64'd0, 10'd0);
	endtask

	task automatic test_clipping();
		send_item(OP_DRAW, 8'd60, 8'd124, 4'd8, 4'd8, PIX_ONES, 10'd0);
		send_item(OP_READ, 8'd0, 8'd0, 4'd0, 4'd0, 64'd0, 10'd1020);
		send_item(OP_DRAW, 8'd255, 8'd255, 4'd8, 4'd8, PIX_ONES, 10'd0);
		send_item(OP_DRAW, 8'd64, 8'd0, 4'd8, 4'd8, PIX_ONES, 10'd0);
		send_item(OP_READ, 8'd0, 8'd0, 4'd0, 4'd0, 64'd0, 10'd1023);
	endtask

	// Unused code, empty sprite, oversized sprite and an odd-sized sprite.
	task automatic test_special_cases();
		send_item(OP_UNUSED, 8'd8, 8'd8, 4'd8, 4'd8, PIX_ONES, 10'd136);
		send_item(OP_DRAW, 8'd8, 8'd8, 4'd0, 4'd4, PIX_ONES, 10'd0);
		send_item(OP_DRAW, 8'd8, 8'd8, 4'd15, 4'd15, {$urandom, $urandom}, 10'd0);
		send_item(OP_READ, 8'd0, 8'd0, 4'd0, 4'd0, 64'd0, 10'd136);
		send_item(OP_DRAW, 8'd13, 8'd40, 4'd3, 4'd5, {$urandom, $urandom}, 10'd0);
		send_item(OP_READ, 8'd0, 8'd0, 4'd0, 4'd0, 64'd0, 10'd168);
	endtask

	task automatic test_clear_frame();
		send_item(OP_CLEAR, 8'd0, 8'd0, 4'd0, 4'd0, 64'd0, 10'd0);
		send_item(OP_READ, 8'd0, 8'd0, 4'd0, 4'd0, 64'd0, 10'd136);
		send_item(OP_READ, 8'd0, 8'd0, 4'd0, 4'd0, 64'd0, 10'd1020);
	endtask

	// Most reads target pixels near the latest sprite so that drawn bytes get checked.
	task automatic test_random_traffic(int n_items);
		int r, x, y, w, h, a, px, py;
		logic [1:0] op;
		logic [63:0] pix;
		repeat (n_items) begin
			r = $urandom_range(0, 99);
			x = $urandom_range(0, 255);
			y = $urandom_range(0, 255);
			w = $urandom_range(0, 15);
			h = $urandom_range(0, 15);
			pix = {$urandom, $urandom};
			a = $urandom_range(0, 1023);
			if (r < 2) begin
				op = OP_CLEAR;
			end else if (r < 5) begin
				op = OP_UNUSED;
			end else if (r < 52) begin
				op = OP_DRAW;
				if ($urandom_range(0, 9) != 0) begin
					w = $urandom_range(1, 8);
					h = $urandom_range(1, 8);
				end
				if ($urandom_range(0, 6) != 0) begin
					x = $urandom_range(0, FB_W - 1);
					y = $urandom_range(0, FB_H - 1);
				end
				last_x = x;
				last_y = y;
			end else begin
				op = OP_READ;
				if ($urandom_range(0, 9) < 7) begin
					px = last_x + $urandom_range(0, 7);
					py = last_y + $urandom_range(0, 7);
					if (px < FB_W && py < FB_H)
						a = (px / 8) * FB_H + py;
				end
			end
			send_item(op, x[7:0], y[7:0], w[3:0], h[3:0], pix, a[9:0]);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		foreach (frame_copy[i])
			frame_copy[i] = 8'h00;
		@(posedge clk);

		set_idling(0, 0);
		test_reset_state();
		test_draw_extremes();
		test_clipping();
		test_special_cases();
		test_clear_frame();

		test_random_traffic(RANDOM_PER_PHASE);
		set_idling(53, 0);
		test_random_traffic(RANDOM_PER_PHASE);
		set_idling(0, 53);
		test_random_traffic(RANDOM_PER_PHASE);
		set_idling(9, 9);
		test_random_traffic(RANDOM_PER_PHASE);

		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d draws, %0d reads, %0d clears and %0d unused-code transactions",
			n_draws, n_reads, n_clears, n_unused);
		$display("under four idle and stall mixes; %0d results checked, %0d errors.",
			n_checked, n_errors);
		if (n_errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#(64'd24_000_000);
		$display("TB_ERROR");
		$finish;
	end

endmodule
